// File: rtl/ecc_pkg.sv
// Package with the shared constants, types and helpers of the elevator car controller.
package ecc_pkg;

  // Number of floors served by the car, numbered 1 to NUM_FLOORS.
  localparam int NUM_FLOORS = 16;

  // Internal widths that follow from the floor count.
  localparam int FloorW = $clog2(NUM_FLOORS + 1);
  localparam int IdxW   = $clog2(NUM_FLOORS);

  // Fixed field widths of the transactions.
  localparam int OpW      = 2;
  localparam int CallW    = 5;
  localparam int ModeW    = 3;
  localparam int FloorOutW = 5;
  localparam int DirW     = 2;
  localparam int PendW    = 16;

  // Operation codes of an input transaction.
  typedef enum logic [OpW-1:0] {
    OP_TICK  = 2'd0,
    OP_CALL  = 2'd1,
    OP_ALARM = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Car state machine, one-hot.
  typedef enum logic [4:0] {
    ST_STOPPED = 5'b00001,
    ST_MOVING  = 5'b00010,
    ST_OPENING = 5'b00100,
    ST_CLOSING = 5'b01000,
    ST_BROKEN  = 5'b10000
  } car_state_e;

  // Mode codes reported in the result transaction.
  localparam logic [ModeW-1:0] MODE_STOPPED = 3'd0;
  localparam logic [ModeW-1:0] MODE_MOVING  = 3'd1;
  localparam logic [ModeW-1:0] MODE_OPENING = 3'd2;
  localparam logic [ModeW-1:0] MODE_CLOSING = 3'd3;
  localparam logic [ModeW-1:0] MODE_BROKEN  = 3'd4;

  // Travel directions.
  localparam logic signed [DirW-1:0] DIR_DOWN = -2'sd1;
  localparam logic signed [DirW-1:0] DIR_NONE = 2'sd0;
  localparam logic signed [DirW-1:0] DIR_UP   = 2'sd1;

  // Complete architectural state of the car.
  typedef struct packed {
    car_state_e                state;
    logic [FloorW-1:0]         floor;
    logic signed [DirW-1:0]    dir;
    logic [NUM_FLOORS-1:0]     mask;
  } car_t;

  // Maps the one-hot state onto the reported mode code.
  function automatic logic [ModeW-1:0] mode_code(car_state_e st);
    logic [ModeW-1:0] code;
    case (st)
      ST_STOPPED: code = MODE_STOPPED;
      ST_MOVING:  code = MODE_MOVING;
      ST_OPENING: code = MODE_OPENING;
      ST_CLOSING: code = MODE_CLOSING;
      ST_BROKEN:  code = MODE_BROKEN;
      default:    code = MODE_STOPPED;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/ecc_intf.sv
// Handshake interfaces for the input and result channels of the car controller.
interface ecc_in_if;
  logic                       valid;
  logic                       ready;
  logic [ecc_pkg::OpW-1:0]    operation;
  logic [ecc_pkg::CallW-1:0]  call_floor;

  modport source (output valid, output operation, output call_floor, input ready);
  modport sink   (input valid, input operation, input call_floor, output ready);
endinterface

interface ecc_out_if;
  logic                             valid;
  logic                             ready;
  logic [ecc_pkg::ModeW-1:0]        car_mode;
  logic [ecc_pkg::FloorOutW-1:0]    floor_now;
  logic signed [ecc_pkg::DirW-1:0]  heading;
  logic [ecc_pkg::PendW-1:0]        pending_calls;

  modport source (output valid, output car_mode, output floor_now, output heading,
                  output pending_calls, input ready);
  modport sink   (input valid, input car_mode, input floor_now, input heading,
                  input pending_calls, output ready);
endinterface

// File: rtl/ecc_step.sv
// Next-state logic of the car: applies one tick, call or alarm to the car state.
module ecc_step (
  input  ecc_pkg::car_t                 car_i,
  input  ecc_pkg::op_e                  op_i,
  input  logic [ecc_pkg::CallW-1:0]     call_floor_i,
  output ecc_pkg::car_t                 car_o
);
  import ecc_pkg::*;

  localparam int StepW = FloorW + 2;

  logic [NUM_FLOORS-1:0]   below;
  logic [NUM_FLOORS-1:0]   above;
  logic [NUM_FLOORS-1:0]   here;
  logic                    found_b;
  logic                    found_a;
  logic [IdxW-1:0]         idx_b;
  logic [IdxW-1:0]         idx_a;
  logic [FloorW-1:0]       dist_b;
  logic [FloorW-1:0]       dist_a;
  logic signed [StepW-1:0] fwd;
  logic signed [StepW-1:0] nxt;
  logic signed [DirW-1:0]  dir_new;
  logic                    ahead;
  logic                    call_ok;

  // Split the pending requests relative to the car position.
  always_comb begin
    for (int i = 0; i < NUM_FLOORS; i++) begin
      below[i] = car_i.mask[i] && (i + 1 < int'(car_i.floor));
      above[i] = car_i.mask[i] && (i + 1 > int'(car_i.floor));
      here[i]  = car_i.mask[i] && (i + 1 == int'(car_i.floor));
    end
  end

  // Nearest request below (highest set bit) and above (lowest set bit).
  always_comb begin
    found_b = 1'b0;
    idx_b   = '0;
    for (int i = 0; i < NUM_FLOORS; i++) begin
      if (below[i]) begin
        found_b = 1'b1;
        idx_b   = IdxW'(i);
      end
    end
    found_a = 1'b0;
    idx_a   = '0;
    for (int i = NUM_FLOORS - 1; i >= 0; i--) begin
      if (above[i]) begin
        found_a = 1'b1;
        idx_a   = IdxW'(i);
      end
    end
  end

  assign dist_b = car_i.floor - (FloorW'(idx_b) + FloorW'(1));
  assign dist_a = (FloorW'(idx_a) + FloorW'(1)) - car_i.floor;

  // Whether a request lies ahead in the current heading.
  always_comb begin
    if (car_i.dir == DIR_DOWN) begin
      ahead = |below;
    end else if (car_i.dir == DIR_UP) begin
      ahead = |above;
    end else begin
      ahead = 1'b0;
    end
  end

  // Reverse at the shaft ends or when nothing lies ahead, then take one step.
  assign fwd = $signed({2'b00, car_i.floor}) + StepW'(car_i.dir);
  assign dir_new = (fwd == StepW'(NUM_FLOORS + 1) || fwd == '0 || !ahead) ?
                   -car_i.dir : car_i.dir;
  assign nxt = $signed({2'b00, car_i.floor}) + StepW'(dir_new);

  assign call_ok = (call_floor_i != '0) && (int'(call_floor_i) <= NUM_FLOORS);

  // Apply the transaction to the car state.
  always_comb begin
    car_o = car_i;
    case (op_i)
      OP_TICK: begin
        if (car_i.mask == '0) begin
          if (car_i.state != ST_BROKEN) begin
            car_o.state = ST_STOPPED;
          end
        end else begin
          case (car_i.state)
            ST_STOPPED: begin
              car_o.state = ST_MOVING;
              if (|here) begin
                car_o.dir = DIR_NONE;
              end else if (found_b && (!found_a || dist_b <= dist_a)) begin
                car_o.dir = DIR_DOWN;
              end else if (found_a) begin
                car_o.dir = DIR_UP;
              end
            end
            ST_MOVING: begin
              if (|here) begin
                car_o.state = ST_OPENING;
              end else begin
                if (car_i.dir == DIR_NONE) begin
                  car_o.state = ST_STOPPED;
                end
                car_o.dir = dir_new;
                if (nxt >= StepW'(1) && nxt <= StepW'(NUM_FLOORS)) begin
                  car_o.floor = FloorW'(nxt);
                end
              end
            end
            ST_OPENING: car_o.state = ST_CLOSING;
            ST_CLOSING: begin
              car_o.mask  = car_i.mask & ~here;
              car_o.state = ST_MOVING;
            end
            default: car_o = car_i;
          endcase
        end
      end
      OP_CALL: begin
        if (call_ok) begin
          car_o.mask[IdxW'(call_floor_i - CallW'(1))] = 1'b1;
        end
      end
      OP_ALARM: car_o.state = ST_BROKEN;
      default:  car_o = car_i;
    endcase
  end

endmodule

// File: rtl/elevator_car_controller_unit.sv
// Single elevator car controller: takes ticks, floor calls and alarms, reports car status.
// Each input transaction (tick, floor call or alarm) yields exactly one result transaction
// that reports the car mode, floor, heading and pending requests after that transaction.
// A transaction may be accepted in every clock cycle unless the result side stalls; its
// result passes an input register and then one pass of the next-state logic into the result
// register. Input and result sides are decoupled by these registers, so a stalled result
// only holds back the input once both stages are full. There is no start-up sequence: the
// input is ready as soon as reset is released.
module elevator_car_controller_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  ecc_in_if.sink           item_i,
  ecc_out_if.source        result_o
);
  import ecc_pkg::*;

  logic                 s1_valid_q, s1_valid_d;
  op_e                  op_q;
  logic [CallW-1:0]     call_floor_q;
  logic                 out_valid_q, out_valid_d;
  car_t                 car_q, car_d, car_next;
  logic                 advance;
  logic                 take;

  logic [ModeW-1:0]        mode_q;
  logic [FloorOutW-1:0]    floor_q;
  logic signed [DirW-1:0]  heading_q;
  logic [PendW-1:0]        pend_q;

  // Stage handshakes: the result stage frees when empty or taken.
  assign advance      = !out_valid_q || result_o.ready;
  assign item_i.ready = !s1_valid_q || advance;
  assign take         = item_i.valid && item_i.ready;

  assign s1_valid_d  = take ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
  assign out_valid_d = advance ? s1_valid_q : out_valid_q;
  assign car_d       = (advance && s1_valid_q) ? car_next : car_q;

  ecc_step u_step (
    .car_i        (car_q),
    .op_i         (op_q),
    .call_floor_i (call_floor_q),
    .car_o        (car_next)
  );

  // Control state and car state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      car_q.state <= ST_STOPPED;
      car_q.floor <= FloorW'(1);
      car_q.dir   <= DIR_NONE;
      car_q.mask  <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      car_q       <= car_d;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q         <= op_e'(item_i.operation);
      call_floor_q <= item_i.call_floor;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      mode_q    <= mode_code(car_next.state);
      floor_q   <= FloorOutW'(car_next.floor);
      heading_q <= car_next.dir;
      pend_q    <= PendW'(car_next.mask);
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.car_mode      = mode_q;
  assign result_o.floor_now     = floor_q;
  assign result_o.heading       = heading_q;
  assign result_o.pending_calls = pend_q;

  // Once broken, the car stays broken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    car_q.state == ST_BROKEN |=> car_q.state == ST_BROKEN)
    else $error("broken car left the broken state");

  // The car never leaves the shaft.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    car_q.floor >= FloorW'(1) && int'(car_q.floor) <= NUM_FLOORS)
    else $error("car floor out of range");

  // Requests are only cleared when the doors close.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (car_q.mask & ~car_d.mask) != '0 |-> car_q.state == ST_CLOSING)
    else $error("request cleared outside closing");

  // An item leaving the input stage always lands in the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && advance |=> out_valid_q)
    else $error("transaction lost between stages");

  // Heading only takes the three legal values.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    car_q.dir != 2'b10)
    else $error("illegal heading");

endmodule

// File: verif/tb_elevator_car_controller_unit.sv
// Self-checking testbench for the elevator car controller unit.
`timescale 1ns / 1ps

module tb_elevator_car_controller_unit;
  import ecc_pkg::*;

  // Status of the car as it is reported in one result transaction.
  typedef struct packed {
    logic [ModeW-1:0]        mode;
    logic [FloorOutW-1:0]    floor;
    logic signed [DirW-1:0]  heading;
    logic [PendW-1:0]        pending;
  } status_t;

  // One row of the directed stimulus; the status is only used where typed is set.
  typedef struct packed {
    op_e                 op;
    logic [CallW-1:0]    floor;
    bit                  typed;
    status_t             status;
  } row_t;

  localparam int      OPENING_ROWS = 24;
  localparam int      ALL_ROWS     = 30;
  localparam int      RANDOM_STOP  = 620;
  localparam int      STEADY_FROM  = 520;
  localparam status_t AT_REST      = '{MODE_STOPPED, 5'd1, DIR_NONE, 16'h0000};
  localparam status_t NO_CHECK     = '0;

  // The opening rows walk the car from reset through every state but broken; the last rows break it.
  localparam row_t DIRECTED_ROWS [ALL_ROWS] = '{
    '{OP_TICK,  5'd0,  1'b1, AT_REST},
    '{OP_NONE,  5'd5,  1'b1, AT_REST},
    '{OP_CALL,  5'd0,  1'b1, AT_REST},
    '{OP_CALL,  5'd17, 1'b1, AT_REST},
    '{OP_CALL,  5'd31, 1'b1, AT_REST},
    '{OP_CALL,  5'd16, 1'b1, '{MODE_STOPPED, 5'd1, DIR_NONE, 16'h8000}},
    '{OP_CALL,  5'd1,  1'b1, '{MODE_STOPPED, 5'd1, DIR_NONE, 16'h8001}},
    '{OP_TICK,  5'd0,  1'b1, '{MODE_MOVING,  5'd1, DIR_NONE, 16'h8001}},
    '{OP_TICK,  5'd31, 1'b1, '{MODE_OPENING, 5'd1, DIR_NONE, 16'h8001}},
    '{OP_TICK,  5'd0,  1'b1, '{MODE_CLOSING, 5'd1, DIR_NONE, 16'h8001}},
    '{OP_TICK,  5'd0,  1'b1, '{MODE_MOVING,  5'd1, DIR_NONE, 16'h8000}},
    '{OP_TICK,  5'd0,  1'b1, '{MODE_STOPPED, 5'd1, DIR_NONE, 16'h8000}},
    '{OP_TICK,  5'd0,  1'b1, '{MODE_MOVING,  5'd1, DIR_UP,   16'h8000}},
    '{OP_CALL,  5'd3,  1'b1, '{MODE_MOVING,  5'd1, DIR_UP,   16'h8004}},
    '{OP_TICK,  5'd0,  1'b1, '{MODE_MOVING,  5'd2, DIR_UP,   16'h8004}},
    '{OP_TICK,  5'd0,  1'b1, '{MODE_MOVING,  5'd3, DIR_UP,   16'h8004}},
    '{OP_TICK,  5'd0,  1'b1, '{MODE_OPENING, 5'd3, DIR_UP,   16'h8004}},
    '{OP_TICK,  5'd0,  1'b1, '{MODE_CLOSING, 5'd3, DIR_UP,   16'h8004}},
    '{OP_TICK,  5'd0,  1'b1, '{MODE_MOVING,  5'd3, DIR_UP,   16'h8000}},
    '{OP_CALL,  5'd2,  1'b0, NO_CHECK},
    '{OP_TICK,  5'd0,  1'b0, NO_CHECK},
    '{OP_CALL,  5'd10, 1'b0, NO_CHECK},
    '{OP_TICK,  5'd0,  1'b0, NO_CHECK},
    '{OP_TICK,  5'd0,  1'b0, NO_CHECK},
    '{OP_ALARM, 5'd0,  1'b0, NO_CHECK},
    '{OP_TICK,  5'd0,  1'b0, NO_CHECK},
    '{OP_CALL,  5'd16, 1'b0, NO_CHECK},
    '{OP_TICK,  5'd31, 1'b0, NO_CHECK},
    '{OP_NONE,  5'd31, 1'b0, NO_CHECK},
    '{OP_ALARM, 5'd21, 1'b0, NO_CHECK}
  };

  logic clk = 1'b0;
  logic rst_n;

  ecc_in_if  car_in ();
  ecc_out_if car_out ();

  elevator_car_controller_unit i_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .item_i   (car_in.sink),
    .result_o (car_out.source)
  );

  // Predicted car state, starting from the reset values.
  logic [ModeW-1:0]       sim_mode     = MODE_STOPPED;
  int                     sim_floor    = 1;
  logic signed [DirW-1:0] sim_heading  = DIR_NONE;
  logic [NUM_FLOORS-1:0]  sim_requests = '0;

  status_t car_status_q [$];
  int      fail_count    = 0;
  int      items_sent    = 0;
  int      idle_odds     = 15;
  int      stall_odds    = 15;
  bit      steady        = 1'b0;
  bit      long_hold_req = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Applies one transaction to the predicted car state.
  task advance_car(input op_e op, input logic [CallW-1:0] cf);
    int f;
    int gap;
    int best;
    int target;
    bit ahead;
    case (op)
      OP_CALL: begin
        if (cf >= 1 && cf <= NUM_FLOORS) sim_requests[cf-1] = 1'b1;
      end
      OP_ALARM: sim_mode = MODE_BROKEN;
      OP_TICK: begin
        if (sim_requests == '0) begin
          if (sim_mode != MODE_BROKEN) sim_mode = MODE_STOPPED;
        end else begin
          case (sim_mode)
            MODE_STOPPED: begin
              // Head for the nearest request; the lower floor wins a tie.
              sim_mode = MODE_MOVING;
              best = NUM_FLOORS + 1;
              for (f = 1; f <= NUM_FLOORS; f++) begin
                if (sim_requests[f-1]) begin
                  gap = (f > sim_floor) ? f - sim_floor : sim_floor - f;
                  if (gap < best) begin
                    best = gap;
                    sim_heading = (f < sim_floor) ? DIR_DOWN :
                                  (f > sim_floor) ? DIR_UP : DIR_NONE;
                  end
                end
              end
            end
            MODE_MOVING: begin
              if (sim_requests[sim_floor-1]) begin
                sim_mode = MODE_OPENING;
              end else begin
                // Look for a request ahead; turn round at the ends or when there is none.
                ahead = 1'b0;
                if (sim_heading == DIR_DOWN) begin
                  for (f = 1; f < sim_floor; f++) ahead |= sim_requests[f-1];
                end else if (sim_heading == DIR_UP) begin
                  for (f = sim_floor + 1; f <= NUM_FLOORS; f++) ahead |= sim_requests[f-1];
                end else begin
                  sim_mode = MODE_STOPPED;
                end
                target = sim_floor + int'(sim_heading);
                if (target == NUM_FLOORS + 1 || target == 0 || !ahead) sim_heading = -sim_heading;
                target = sim_floor + int'(sim_heading);
                if (target >= 1 && target <= NUM_FLOORS) sim_floor = target;
              end
            end
            MODE_OPENING: sim_mode = MODE_CLOSING;
            MODE_CLOSING: begin
              sim_requests[sim_floor-1] = 1'b0;
              sim_mode = MODE_MOVING;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  endtask

  // Offers one transaction, waits for it to be taken and records the status it must produce.
  task automatic send_item(input op_e op, input logic [CallW-1:0] cf,
                           input bit typed = 1'b0, input status_t typed_status = '0);
    if (idle_odds != 0 && $urandom_range(1, 100) <= idle_odds) begin
      car_in.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    car_in.valid      <= 1'b1;
    car_in.operation  <= op;
    car_in.call_floor <= cf;
    @(posedge clk);
    while (!car_in.ready) @(posedge clk);
    advance_car(op, cf);
    if (typed) begin
      car_status_q.push_back(typed_status);
    end else begin
      car_status_q.push_back('{sim_mode, FloorOutW'(sim_floor), sim_heading,
                               PendW'(sim_requests)});
    end
    items_sent++;
  endtask

  task automatic play_rows(input int first, input int last);
    for (int i = first; i <= last; i++) begin
      send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].floor,
                DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].status);
    end
  endtask

  // Stops offering and waits until every expected status has been seen.
  task automatic drain_results();
    car_in.valid <= 1'b0;
    while (car_status_q.size() != 0) @(posedge clk);
  endtask

  // Mostly valid floors, now and then one outside the shaft.
  function automatic logic [CallW-1:0] pick_floor();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(0, 1) ? '0 : CallW'($urandom_range(NUM_FLOORS + 1, 2**CallW - 1));
    end
    return CallW'($urandom_range(1, NUM_FLOORS));
  endfunction

  // A journey: one to four calls, then ticks with the odd new call until every request is served or 120 ticks are sent.
  task automatic run_trip();
    int ticks;
    if (!steady) begin
      idle_odds  = ($urandom_range(0, 2) == 0) ? 0 : 12;
      stall_odds = ($urandom_range(0, 2) == 0) ? 0 : 12;
    end
    repeat ($urandom_range(1, 4)) send_item(OP_CALL, pick_floor());
    ticks = 0;
    while (sim_requests != '0 && ticks < 120) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(OP_CALL, pick_floor());
      end else begin
        send_item(OP_TICK, CallW'($urandom_range(0, 2**CallW - 1)));
        ticks++;
      end
    end
    repeat ($urandom_range(1, 2)) send_item(OP_TICK, CallW'($urandom_range(0, 2**CallW - 1)));
  endtask

  // Holds the result side for a long stretch while a journey is offered, then drains.
  task automatic choke_and_drain();
    long_hold_req = 1'b1;
    run_trip();
    drain_results();
  endtask

  // Noise: stray calls, unknown operations and ticks, never an alarm.
  task automatic run_noise();
    op_e op;
    repeat ($urandom_range(1, 4)) begin
      op = op_e'($urandom_range(0, 3));
      if (op == OP_ALARM) op = OP_TICK;
      send_item(op, CallW'($urandom_range(0, 2**CallW - 1)));
    end
  endtask

  // Result side: ready drops in short random bursts, or for a long hold on request.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    car_out.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = 40;
      end else if (stall_left == 0 && !steady && stall_odds != 0 &&
                   $urandom_range(1, 100) <= stall_odds) begin
        stall_left = $urandom_range(1, 5);
      end
      if (stall_left != 0) begin
        car_out.ready <= 1'b0;
        stall_left--;
      end else begin
        car_out.ready <= 1'b1;
      end
    end
  end

  // Every accepted result transaction is compared with the oldest expected status.
  always @(posedge clk) begin : check_results
    status_t seen;
    status_t want;
    if (rst_n && car_out.valid && car_out.ready) begin
      seen = '{car_out.car_mode, car_out.floor_now, car_out.heading, car_out.pending_calls};
      if (car_status_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("Unexpected result: mode %0d floor %0d heading %0d pending %h",
                   seen.mode, seen.floor, seen.heading, seen.pending);
        end
      end else begin
        want = car_status_q.pop_front();
        if (seen.mode !== want.mode || seen.floor !== want.floor ||
            seen.heading !== want.heading || seen.pending !== want.pending) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("Mismatch: expected mode %0d floor %0d heading %0d pending %h",
                     want.mode, want.floor, want.heading, want.pending);
            $display("          got      mode %0d floor %0d heading %0d pending %h",
                     seen.mode, seen.floor, seen.heading, seen.pending);
          end
        end
      end
    end
  end

  // Stimulus: directed opening, random journeys and noise, then the alarm rows at the very end.
  initial begin : stimulus
    bit mid_choke_done;
    mid_choke_done = 1'b0;
    rst_n = 1'b0;
    car_in.valid      <= 1'b0;
    car_in.operation  <= OP_NONE;
    car_in.call_floor <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    play_rows(0, OPENING_ROWS - 1);
    choke_and_drain();

    while (items_sent < RANDOM_STOP) begin
      if (items_sent >= STEADY_FROM && !steady) begin
        steady     = 1'b1;
        idle_odds  = 0;
        stall_odds = 0;
      end
      if (!mid_choke_done && items_sent >= 300) begin
        mid_choke_done = 1'b1;
        choke_and_drain();
      end else if ($urandom_range(0, 5) == 0) begin
        run_noise();
      end else begin
        run_trip();
      end
    end

    play_rows(OPENING_ROWS, ALL_ROWS - 1);
    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && car_status_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #(1_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
